### rtl/psa_pkg.sv
// Shared types, widths and constants for the pixel saturation adjust pipeline.
package psa_pkg;

  // Field and datapath widths.
  localparam int CHAN_W = 8;
  localparam int GAIN_W = 12;
  localparam int SQ_W   = 2 * CHAN_W;
  localparam int SUM_W  = 26;
  localparam int RAD_W  = SUM_W - 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 1;
  localparam int DIFF_W = ROOT_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int FRAC_W = 12;

  // Luma weights in Q0.10; they sum to 1024.
  localparam logic [9:0] WEIGHT_RED   = 10'd306;
  localparam logic [9:0] WEIGHT_GREEN = 10'd601;
  localparam logic [9:0] WEIGHT_BLUE  = 10'd117;

  // Gain of 1.0 in Q4.8.
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 12'd256;

  // Input pixel.
  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pix_t;

  // Adjusted pixel.
  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              clipped;
  } res_t;

  // Token handed from one square root cell to the next.
  typedef struct packed {
    logic              valid;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
    pix_t              pix;
  } sqrt_cell_t;

endpackage

### rtl/psa_lum.sv
// Squares and weighted sum that form the radicand of the brightness root.
module psa_lum (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  psa_pkg::pix_t      in_pix,
  output psa_pkg::sqrt_cell_t seed
);
  import psa_pkg::*;

  logic            sq_valid;
  pix_t            sq_pix;
  logic [SQ_W-1:0] sq_r;
  logic [SQ_W-1:0] sq_g;
  logic [SQ_W-1:0] sq_b;
  logic [SUM_W-1:0] sum_next;

  // Valid bit of the square stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (adv) begin
      sq_valid <= in_valid;
    end
  end

  // Stage one: channel squares.
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_pix <= in_pix;
      sq_r   <= SQ_W'(in_pix.red_in) * SQ_W'(in_pix.red_in);
      sq_g   <= SQ_W'(in_pix.green_in) * SQ_W'(in_pix.green_in);
      sq_b   <= SQ_W'(in_pix.blue_in) * SQ_W'(in_pix.blue_in);
    end
  end

  // Weighted sum of squares by constant coefficients.
  always_comb begin
    sum_next = SUM_W'(WEIGHT_RED) * SUM_W'(sq_r)
             + SUM_W'(WEIGHT_GREEN) * SUM_W'(sq_g)
             + SUM_W'(WEIGHT_BLUE) * SUM_W'(sq_b);
  end

  // Stage two: quarter of the sum seeds the root chain with an empty root.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed.valid <= 1'b0;
    end else if (adv) begin
      seed.valid <= sq_valid;
    end
    if (adv) begin
      seed.rem  <= '0;
      seed.root <= '0;
      seed.rad  <= sum_next[SUM_W-1:2];
      seed.pix  <= sq_pix;
    end
  end

endmodule

### rtl/psa_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per stage.
module psa_sqrt_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  psa_pkg::sqrt_cell_t prev,
  output psa_pkg::sqrt_cell_t next
);
  import psa_pkg::*;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             take;
  logic [REM_W-1:0] rem_next;
  logic [ROOT_W-1:0] root_next;

  // Bring down the next two radicand bits and try the odd subtrahend.
  always_comb begin
    rem_sh = {prev.rem, prev.rad[RAD_W-1 -: 2]};
    trial  = {1'b0, prev.root, 2'b01};
    take   = (rem_sh >= trial);
    if (take) begin
      rem_next  = REM_W'(rem_sh - trial);
      root_next = {prev.root[ROOT_W-2:0], 1'b1};
    end else begin
      rem_next  = rem_sh[REM_W-1:0];
      root_next = {prev.root[ROOT_W-2:0], 1'b0};
    end
  end

  // Valid bit, partial root, remainder and pixel move on to the neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (adv) begin
      next.valid <= prev.valid;
    end
    if (adv) begin
      next.rem  <= rem_next;
      next.root <= root_next;
      next.rad  <= {prev.rad[RAD_W-3:0], 2'b00};
      next.pix  <= prev.pix;
    end
  end

  // The remainder never exceeds twice the partial root.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    next.valid |-> ({1'b0, next.rem} <= {1'b0, next.root, 1'b0}))
    else $error("square root remainder out of bound");

endmodule

### rtl/psa_adjust.sv
// Saturation blend around the brightness, with rounding and clamping.
module psa_adjust (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic [psa_pkg::GAIN_W-1:0] gain,
  input  psa_pkg::sqrt_cell_t       tok,
  output logic                      out_valid,
  output psa_pkg::res_t             out_res
);
  import psa_pkg::*;

  logic                     prod_valid;
  logic [ROOT_W-1:0]        prod_root;
  logic signed [PROD_W-1:0] prod [3];
  logic [CHAN_W-1:0]        chan [3];
  logic signed [DIFF_W-1:0] diff [3];
  logic signed [ACC_W-1:0]  acc [3];
  logic [CHAN_W-1:0]        val_next [3];
  logic [2:0]               clip_next;

  // Signed distance of each channel from the brightness, Q8.4.
  always_comb begin
    chan[0] = tok.pix.red_in;
    chan[1] = tok.pix.green_in;
    chan[2] = tok.pix.blue_in;
    for (int i = 0; i < 3; i++) begin
      diff[i] = $signed({1'b0, chan[i], 4'b0000}) - $signed({1'b0, tok.root});
    end
  end

  // Valid bits of the multiply and output stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (adv) begin
      prod_valid <= tok.valid;
      out_valid  <= prod_valid;
    end
  end

  // Multiply stage: distance times gain.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_root <= tok.root;
      for (int i = 0; i < 3; i++) begin
        prod[i] <= diff[i] * $signed({1'b0, gain});
      end
    end
  end

  // Add the brightness back, round half up, then clamp to the channel range.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = $signed({{(ACC_W-ROOT_W-8){1'b0}}, prod_root, 8'h00})
             + ACC_W'(prod[i])
             + $signed(ACC_W'(1 << (FRAC_W - 1)));
      if (acc[i][ACC_W-1]) begin
        val_next[i]  = '0;
        clip_next[i] = 1'b1;
      end else if (acc[i][ACC_W-2:FRAC_W+CHAN_W] != '0) begin
        val_next[i]  = '1;
        clip_next[i] = 1'b1;
      end else begin
        val_next[i]  = acc[i][FRAC_W +: CHAN_W];
        clip_next[i] = 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_res.red_out   <= val_next[0];
      out_res.green_out <= val_next[1];
      out_res.blue_out  <= val_next[2];
      out_res.clipped   <= |clip_next;
    end
  end

  // Unity gain reproduces the input, so nothing can clip.
  a_unity_no_clip: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gain == GAIN_UNITY) |-> !out_res.clipped)
    else $error("clip reported at unity gain");

  // Zero gain gives grey: all three channels equal.
  a_zero_grey: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gain == '0) |->
      (out_res.red_out == out_res.green_out && out_res.green_out == out_res.blue_out))
    else $error("zero gain result is not grey");

endmodule

### rtl/pixel_saturation_adjust_core.sv
// Top level of the pixel saturation adjust pipeline.
//
// Usage: RGB pixels enter on the pix channel (pix_valid/pix_ready/pix) and
// adjusted pixels leave on the res channel (res_valid/res_ready/res). Each
// transfer moves one pixel. The brightness is the square root of the
// weighted channel squares; each channel is pushed away from or toward it
// by the Q4.8 gain written on cfg_wr_en/cfg_wr_data, then rounded and
// clamped to 0..255 with res.clipped set when any channel was clamped.
// From an input transfer, a pixel passes through the square stage, the
// weighted sum stage, the chain of square root cells (one root bit per
// cell), the multiply stage and the output register. Throughput is one
// pixel per clock while the receiver keeps taking results; the root chain
// is the deepest part of the pipeline. When the receiver stalls, the whole
// pipeline holds and pix_ready drops, so the held result stays on res.
// Reset clears all valid bits and sets the gain to 1.0 (256). Write the
// gain only while no pixel is in flight.
module pixel_saturation_adjust_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pix_valid,
  output logic                      pix_ready,
  input  psa_pkg::pix_t             pix,
  output logic                      res_valid,
  input  logic                      res_ready,
  output psa_pkg::res_t             res,
  input  logic                      cfg_wr_en,
  input  logic [psa_pkg::GAIN_W-1:0] cfg_wr_data
);
  import psa_pkg::*;

  logic              adv;
  logic [GAIN_W-1:0] gain;
  sqrt_cell_t        link [ROOT_W+1];

  // The pipeline moves whenever the output slot is empty or being taken.
  assign adv       = !res_valid || res_ready;
  assign pix_ready = adv;

  // Gain register.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_UNITY;
    end else if (cfg_wr_en) begin
      gain <= cfg_wr_data;
    end
  end

  // Squares and weighted sum.
  psa_lum u_lum (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (pix_valid),
    .in_pix   (pix),
    .seed     (link[0])
  );

  // Chain of root cells, one result bit each.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    psa_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .prev (link[k]),
      .next (link[k+1])
    );
  end

  // Blend, round and clamp.
  psa_adjust u_adjust (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .gain      (gain),
    .tok       (link[ROOT_W]),
    .out_valid (res_valid),
    .out_res   (res)
  );

  // No result is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule
